>>> rtl/qse_pkg.sv
package qse_pkg;

	// Table geometry.
	localparam int MAX_SEGMENTS     = 256;
	localparam int COEF_PER_SEGMENT = 6;
	localparam int SEG_W            = $clog2(MAX_SEGMENTS);
	localparam int SLOT_W           = 3;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Number of outputs in the derivative chain, and multiply-add steps per chain.
	localparam int NUM_DERIV = 5;
	localparam int NUM_STEPS = 5;
	// Register stages in one multiply-add step.
	localparam int STEP_LAT  = 3;
	localparam int CHAIN_LAT = NUM_STEPS * STEP_LAT;

	// Command codes of the input transaction.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_START_TIME    = 2'd0;
	localparam logic [1:0] REG_INV_STEP      = 2'd1;
	localparam logic [1:0] REG_SEGMENT_COUNT = 2'd2;

	// Entry passed from the front to the back.
	typedef struct packed {
		logic              is_eval;
		logic [SEG_W-1:0]  seg;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       coef;
		logic [31:0]       arg;
		logic              clamped;
		logic              sat;
	} q_entry_t;

	// Side information that travels alongside the multiply-add chains.
	typedef struct packed {
		logic                                    valid;
		logic                                    clamped;
		logic                                    sat;
		logic [31:0]                             arg;
		logic [COEF_PER_SEGMENT-1:0][31:0]       coef;
	} info_t;

	// Falling factorial n!/(n-d)! for derivative d of the power n term.
	function automatic logic [7:0] falling(input int d, input int n);
		logic [7:0] r;
		r = 8'd1;
		for (int i = 0; i < 5; i++) begin
			if (i < d) begin
				r = (n - i > 0) ? 8'(r * (n - i)) : 8'd0;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/qse_ram.sv
module qse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/qse_queue.sv
module qse_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qse_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output qse_pkg::q_entry_t pop_data
);
	import qse_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	q_entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/qse_front.sv
module qse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        seg_index,
	input  logic [2:0]        coef_slot,
	input  logic [31:0]       coef_value,
	input  logic [31:0]       eval_time,
	input  logic [31:0]       start_time,
	input  logic [31:0]       inv_step,
	input  logic [8:0]        segment_count,
	output logic              push,
	output qse_pkg::q_entry_t push_data,
	input  logic              q_full
);
	import qse_pkg::*;

	logic        valid_s1;
	logic        eval_s1;
	logic [7:0]  seg_s1;
	logic [2:0]  slot_s1;
	logic [31:0] coef_s1;
	logic        neg_s1;
	logic [63:0] mag_s1;

	logic signed [32:0] diff;
	logic [32:0]        abs_diff;
	logic               advance;

	logic [31:0]        frac;
	logic signed [33:0] ip;
	logic [8:0]         n_seg;
	logic [8:0]         k;
	logic signed [33:0] whole;
	logic [31:0]        arg;
	logic               arg_sat;

	assign advance  = !valid_s1 || !q_full;
	assign in_ready = advance;
	assign push     = valid_s1 && !q_full;

	// Offset from the grid origin and its magnitude.
	assign diff     = $signed({eval_time[31], eval_time}) - $signed({start_time[31], start_time});
	assign abs_diff = diff[32] ? 33'(-diff) : 33'(diff);

	// Accept stage: scale the offset by the inverse step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			eval_s1 <= (cmd == CMD_EVAL);
			seg_s1  <= seg_index;
			slot_s1 <= coef_slot;
			coef_s1 <= coef_value;
			neg_s1  <= diff[32];
			mag_s1  <= 64'(65'(abs_diff) * 65'(inv_step));
		end
	end

	// Floor of the grid position, then segment selection and local argument.
	always_comb begin
		if (neg_s1) begin
			ip   = -$signed({2'b00, mag_s1[63:32]}) - ((mag_s1[31:0] != '0) ? 34'sd1 : 34'sd0);
			frac = 32'(0) - mag_s1[31:0];
		end else begin
			ip   = $signed({2'b00, mag_s1[63:32]});
			frac = mag_s1[31:0];
		end

		if (segment_count == '0) begin
			n_seg = 9'd1;
		end else if (segment_count > 9'(MAX_SEGMENTS)) begin
			n_seg = 9'(MAX_SEGMENTS);
		end else begin
			n_seg = segment_count;
		end

		if (ip[33]) begin
			k = '0;
		end else if (ip > $signed({25'b0, n_seg - 9'd1})) begin
			k = n_seg - 9'd1;
		end else begin
			k = ip[8:0];
		end

		whole   = ip - $signed({25'b0, k});
		arg_sat = 1'b0;
		if (whole > 34'sd127) begin
			arg     = 32'h7FFF_FFFF;
			arg_sat = 1'b1;
		end else if (whole < -34'sd128) begin
			arg     = 32'h8000_0000;
			arg_sat = 1'b1;
		end else begin
			arg = {whole[7:0], frac[31:8]};
		end
	end

	// Queue entry: a load keeps its address, an evaluation its segment.
	always_comb begin
		push_data.is_eval = eval_s1;
		push_data.seg     = eval_s1 ? k[SEG_W-1:0] : seg_s1[SEG_W-1:0];
		push_data.slot    = slot_s1;
		push_data.coef    = coef_s1;
		push_data.arg     = arg;
		push_data.clamped = ($signed({25'b0, k}) != ip);
		push_data.sat     = arg_sat;
	end

endmodule

>>> rtl/qse_step.sv
module qse_step (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] acc_in,
	input  logic signed [32:0] mul_b,
	input  logic               sh16,
	input  logic signed [63:0] add_c,
	input  logic               sat_in,
	output logic signed [63:0] acc_out,
	output logic               sat_out
);

	logic        neg;
	logic [63:0] ua;
	logic [32:0] ub;

	logic [64:0]        lo_s1;
	logic [64:0]        hi_s1;
	logic               neg_s1;
	logic               sh16_s1;
	logic signed [63:0] c_s1;
	logic               sat_s1;

	logic [96:0] prod;
	logic [96:0] m;
	logic        over;
	logic [63:0] mval;

	logic signed [63:0] m_s2;
	logic signed [63:0] c_s2;
	logic               sat_s2;

	logic [64:0] sum;
	logic        ovf;

	// Sign and magnitudes of the operands.
	assign neg = acc_in[63] ^ mul_b[32];
	assign ua  = acc_in[63] ? 64'(-acc_in) : 64'(acc_in);
	assign ub  = mul_b[32] ? 33'(-mul_b) : 33'(mul_b);

	// Stage one: two partial products of the magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= 65'(ua[31:0]) * 65'(ub);
			hi_s1   <= 65'(ua[63:32]) * 65'(ub);
			neg_s1  <= neg;
			sh16_s1 <= sh16;
			c_s1    <= add_c;
			sat_s1  <= sat_in;
		end
	end

	// Combine, round towards minus infinity, shift and limit to 64 bits.
	always_comb begin
		prod = {hi_s1, 32'b0} + {32'b0, lo_s1};
		if (neg_s1) begin
			prod = prod + (sh16_s1 ? 97'h0_FFFF : 97'hFF_FFFF);
		end
		m    = sh16_s1 ? (prod >> 16) : (prod >> 24);
		over = (m[96:64] != '0) || (m[63] && (!neg_s1 || (m[62:0] != '0)));
		if (over) begin
			mval = neg_s1 ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end else begin
			mval = neg_s1 ? 64'(0) - m[63:0] : m[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2   <= $signed(mval);
			c_s2   <= c_s1;
			sat_s2 <= sat_s1 | over;
		end
	end

	// Stage three: saturating add of the coefficient term.
	assign sum = {m_s2[63], m_s2} + {c_s2[63], c_s2};
	assign ovf = sum[64] != sum[63];

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf) begin
				acc_out <= sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
			end else begin
				acc_out <= $signed(sum[63:0]);
			end
			sat_out <= sat_s2 | ovf;
		end
	end

endmodule

>>> rtl/qse_back.sv
module qse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  qse_pkg::q_entry_t q_data,
	output logic              pop,
	input  logic [31:0]       inv_step,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [239:0]      out_data,
	output logic [1:0]        out_flags
);
	import qse_pkg::*;

	logic        en;
	logic        valid_s1;
	logic        clamped_s1;
	logic        sat_s1;
	logic [31:0] arg_s1;

	logic [COEF_PER_SEGMENT-1:0][31:0] rdata;
	info_t info0;
	info_t info_q [1:CHAIN_LAT];
	info_t info_a [0:CHAIN_LAT];

	logic signed [63:0] acc  [NUM_DERIV][NUM_STEPS];
	logic               satv [NUM_DERIV][NUM_STEPS];

	logic [NUM_DERIV-1:0][47:0] res;
	logic [NUM_DERIV-1:0]       res_sat;

	// The whole back pipeline moves when the output register can take data.
	assign en  = !out_valid || out_ready;
	assign pop = en && q_valid;

	// Coefficient table: one memory per polynomial power.
	for (genvar s = 0; s < COEF_PER_SEGMENT; s++) begin : g_tab
		qse_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_ram (
			.clk   (clk),
			.we    (pop && !q_data.is_eval && (q_data.slot == SLOT_W'(s))),
			.waddr (q_data.seg),
			.wdata (q_data.coef),
			.re    (en),
			.raddr (q_data.seg),
			.rdata (rdata[s])
		);
	end

	// Read stage alongside the table access.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop && q_data.is_eval;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clamped_s1 <= q_data.clamped;
			sat_s1     <= q_data.sat;
			arg_s1     <= q_data.arg;
		end
	end

	always_comb begin
		info0.valid   = valid_s1;
		info0.clamped = clamped_s1;
		info0.sat     = sat_s1;
		info0.arg     = arg_s1;
		info0.coef    = rdata;
	end

	// Side information delay line matching the chain latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 1; p <= CHAIN_LAT; p++) begin
				info_q[p] <= '0;
			end
		end else if (en) begin
			info_q[1] <= info0;
			for (int p = 2; p <= CHAIN_LAT; p++) begin
				info_q[p] <= info_q[p-1];
			end
		end
	end

	always_comb begin
		info_a[0] = info0;
		for (int p = 1; p <= CHAIN_LAT; p++) begin
			info_a[p] = info_q[p];
		end
	end

	// One chain per derivative: Horner steps, then scaling by the inverse step.
	for (genvar d = 0; d < NUM_DERIV; d++) begin : g_lane
		for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
			localparam int I = NUM_STEPS - 1 - j;
			localparam logic [7:0] F = falling(d, I);

			logic signed [63:0] a_in;
			logic signed [32:0] b_in;
			logic signed [63:0] c_in;
			logic               s_in;
			logic               sh16;
			logic [31:0]        cw;

			always_comb begin
				cw = info_a[STEP_LAT*j].coef[I];
				if (j == 0) begin
					a_in = 64'($signed({{24{info0.coef[5][31]}}, info0.coef[5], 8'b0})
						* $signed({1'b0, falling(d, 5)}));
					s_in = info0.sat;
				end else begin
					a_in = acc[d][j-1];
					s_in = satv[d][j-1];
				end
				if (I >= d) begin
					b_in = $signed({info_a[STEP_LAT*j].arg[31], info_a[STEP_LAT*j].arg});
					c_in = 64'($signed({{24{cw[31]}}, cw, 8'b0}) * $signed({1'b0, F}));
					sh16 = 1'b0;
				end else begin
					b_in = $signed({1'b0, inv_step});
					c_in = '0;
					sh16 = 1'b1;
				end
			end

			qse_step u_step (
				.clk     (clk),
				.en      (en),
				.acc_in  (a_in),
				.mul_b   (b_in),
				.sh16    (sh16),
				.add_c   (c_in),
				.sat_in  (s_in),
				.acc_out (acc[d][j]),
				.sat_out (satv[d][j])
			);
		end

		// Final limit to the 48-bit result range.
		always_comb begin
			res_sat[d] = satv[d][NUM_STEPS-1];
			if (acc[d][NUM_STEPS-1] > 64'sh0000_7FFF_FFFF_FFFF) begin
				res[d]     = 48'h7FFF_FFFF_FFFF;
				res_sat[d] = 1'b1;
			end else if (acc[d][NUM_STEPS-1] < -64'sh0000_8000_0000_0000) begin
				res[d]     = 48'h8000_0000_0000;
				res_sat[d] = 1'b1;
			end else begin
				res[d] = acc[d][NUM_STEPS-1][47:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= info_q[CHAIN_LAT].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data  <= res;
			out_flags <= {|res_sat, info_q[CHAIN_LAT].clamped};
		end
	end

endmodule

>>> rtl/quintic_spline_evaluator_unit.sv
// Quintic spline evaluator on a uniform grid. Load transactions (tuser low) write one Q16.16
// coefficient of one segment into the table; evaluate transactions (tuser high) return the
// Q24.24 value and first to fourth derivatives at the given time, with clamped and saturated
// flags. A segment must be fully loaded before it is evaluated; the table is not cleared by
// reset. One transaction is taken every clock cycle unless the queue is full, loads and
// evaluations mixed freely, and a load is visible to the evaluation that follows it. The
// grid-position multiply is registered at the accepting edge; an evaluation then passes
// the queue (where it waits while the back stalls), the table read, the five multiply-add
// chains (five steps of three stages each) and the output register. Loads produce no
// output transaction.
module quintic_spline_evaluator_unit (
	input  logic         clk,
	input  logic         arst_n,
	// tdata: seg_index[7:0], coef_slot[10:8], coef_value[42:11], eval_time[74:43]
	input  logic [79:0]  s_axis_tdata,
	// tuser: cmd
	input  logic         s_axis_tuser,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: value, first_deriv, second_deriv, third_deriv, fourth_deriv, 48 bits each
	output logic [239:0] m_axis_tdata,
	// tuser: clamped[0], saturated[1]
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import qse_pkg::*;

	logic [31:0] start_time_q;
	logic [31:0] inv_step_q;
	logic [8:0]  segment_count_q;

	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_valid;
	q_entry_t push_data;
	q_entry_t pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q    <= '0;
			inv_step_q      <= 32'd65536;
			segment_count_q <= 9'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_TIME:    start_time_q    <= cfg_data;
				REG_INV_STEP:      inv_step_q      <= cfg_data;
				REG_SEGMENT_COUNT: segment_count_q <= cfg_data[8:0];
				default:           ;
			endcase
		end
	end

	// Front: accepts transactions and works out segment and local argument.
	qse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.cmd           (s_axis_tuser),
		.seg_index     (s_axis_tdata[7:0]),
		.coef_slot     (s_axis_tdata[10:8]),
		.coef_value    (s_axis_tdata[42:11]),
		.eval_time     (s_axis_tdata[74:43]),
		.start_time    (start_time_q),
		.inv_step      (inv_step_q),
		.segment_count (segment_count_q),
		.push          (push),
		.push_data     (push_data),
		.q_full        (q_full)
	);

	qse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_data  (pop_data)
	);

	// Back: table access and the derivative chains.
	qse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.pop       (pop),
		.inv_step  (inv_step_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_flags (m_axis_tuser)
	);

endmodule

>>> tb/qse_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the spline evaluator, predicts each evaluation result and compares.
module qse_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [79:0]  s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [239:0] m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending_count
);
	import qse_pkg::*;

	typedef struct {
		logic [47:0] deriv [5];
		logic        clamped;
		logic        saturated;
	} spline_result_t;

	localparam longint I64_MAX = 64'sh7FFFFFFFFFFFFFFF;
	localparam longint I64_MIN = 64'sh8000000000000000;

	logic [31:0]    coef_store [MAX_SEGMENTS*COEF_PER_SEGMENT];
	logic [31:0]    grid_origin;
	logic [31:0]    grid_inverse;
	logic [8:0]     seg_total;
	spline_result_t expected_results [$];

	assign pending_count = expected_results.size();

	// floor(a * b / 2^sh), saturated to 64 bits signed.
	function automatic longint scale_floor(longint a, longint b, int sh, inout bit sat);
		logic signed [127:0] p;
		logic signed [127:0] q;
		p = 128'(signed'(a)) * 128'(signed'(b));
		q = p >>> sh;
		if (q > 128'(signed'(I64_MAX))) begin
			sat = 1;
			return I64_MAX;
		end
		if (q < 128'(signed'(I64_MIN))) begin
			sat = 1;
			return I64_MIN;
		end
		return longint'(q);
	endfunction

	function automatic longint sum_sat(longint a, longint b, inout bit sat);
		logic signed [65:0] s;
		s = 66'(signed'(a)) + 66'(signed'(b));
		if (s > 66'(signed'(I64_MAX))) begin
			sat = 1;
			return I64_MAX;
		end
		if (s < 66'(signed'(I64_MIN))) begin
			sat = 1;
			return I64_MIN;
		end
		return longint'(s);
	endfunction

	function automatic longint fall_fact(int d, int n);
		longint r;
		r = 1;
		for (int i = 0; i < d; i++) r = r * (n - i);
		return r;
	endfunction

	// One derivative by Horner's rule, then scaled by the inverse step d times.
	function automatic logic [47:0] horner_deriv(int base, int d, longint arg, inout bit sat);
		longint acc;
		longint lim;
		lim = (64'sd1 <<< 47) - 1;
		acc = longint'(signed'(coef_store[base+5])) * 256 * fall_fact(d, 5);
		for (int i = 4; i >= d; i--)
			acc = sum_sat(scale_floor(acc, arg, 24, sat),
				longint'(signed'(coef_store[base+i])) * 256 * fall_fact(d, i), sat);
		for (int i = 0; i < d; i++)
			acc = scale_floor(acc, longint'({32'd0, grid_inverse}), 16, sat);
		if (acc > lim) begin
			sat = 1;
			acc = lim;
		end
		if (acc < -lim - 1) begin
			sat = 1;
			acc = -lim - 1;
		end
		return acc[47:0];
	endfunction

	function automatic spline_result_t evaluate_at(logic [31:0] t);
		spline_result_t r;
		logic signed [33:0] diff;
		logic signed [67:0] u;
		longint ip, k, n, whole, arg;
		bit sat;
		sat = 0;
		diff = 34'(signed'(t)) - 34'(signed'(grid_origin));
		u = 68'(diff) * 68'(signed'({1'b0, grid_inverse}));
		ip = longint'(u >>> 32);
		n = (seg_total == 0) ? 1 : (seg_total > MAX_SEGMENTS ? MAX_SEGMENTS : seg_total);
		k = ip < 0 ? 0 : (ip > n - 1 ? n - 1 : ip);
		r.clamped = (k != ip);
		whole = ip - k;
		if (whole > 127) begin
			sat = 1;
			arg = 64'sh7FFFFFFF;
		end else if (whole < -128) begin
			sat = 1;
			arg = -64'sh80000000;
		end else begin
			arg = whole * (64'sd1 <<< 24) + longint'({40'd0, u[31:8]});
		end
		for (int j = 0; j < 5; j++)
			r.deriv[j] = horner_deriv(int'(k) * COEF_PER_SEGMENT, j, arg, sat);
		r.saturated = sat;
		return r;
	endfunction

	// Track configuration, loads and evaluations; compare each output transaction.
	always @(posedge clk or negedge arst_n) begin
		spline_result_t got;
		spline_result_t want;
		if (!arst_n) begin
			grid_origin  <= 32'd0;
			grid_inverse <= 32'd65536;
			seg_total    <= 9'd1;
			fail_count   <= 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_TIME:    grid_origin <= cfg_data;
					REG_INV_STEP:      grid_inverse <= cfg_data;
					REG_SEGMENT_COUNT: seg_total <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == CMD_LOAD) begin
					if (s_axis_tdata[10:8] < COEF_PER_SEGMENT)
						coef_store[s_axis_tdata[7:0]*COEF_PER_SEGMENT + s_axis_tdata[10:8]] =
							s_axis_tdata[42:11];
				end else begin
					expected_results.push_back(evaluate_at(s_axis_tdata[74:43]));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				for (int j = 0; j < 5; j++) got.deriv[j] = m_axis_tdata[48*j +: 48];
				got.clamped = m_axis_tuser[0];
				got.saturated = m_axis_tuser[1];
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected: %h %b", $time, m_axis_tdata,
						m_axis_tuser);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want != got) begin
						fail_count <= fail_count + 1;
						for (int j = 0; j < 5; j++)
							if (want.deriv[j] != got.deriv[j])
								$display("%0t: derivative %0d expected %h actual %h", $time, j,
									want.deriv[j], got.deriv[j]);
						if (want.clamped != got.clamped)
							$display("%0t: clamped expected %b actual %b", $time,
								want.clamped, got.clamped);
						if (want.saturated != got.saturated)
							$display("%0t: saturated expected %b actual %b", $time,
								want.saturated, got.saturated);
					end
				end
			end
		end
	end

endmodule

>>> tb/tb_quintic_spline_evaluator_unit.sv
`timescale 1ns / 100ps

module tb_quintic_spline_evaluator_unit;
	import qse_pkg::*;

	// Segments loaded up front; the segment count in use never selects beyond them.
	localparam int LOADED_SEGS = 128;

	logic         clk;
	logic         arst_n;
	logic [79:0]  s_axis_tdata;
	logic         s_axis_tuser;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [239:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           fail_count;
	int           pending_count;
	int           cycle_count;
	bit           steady;

	quintic_spline_evaluator_unit dut (.*);
	qse_checker u_checker (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Run limit.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("tb_quintic_spline_evaluator_unit NOT OK");
			$finish;
		end
	end

	// Receiver stalls at random except in the steady stretch.
	always @(negedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= steady || ($urandom_range(99) >= 36);
	end

	// Valid stays high from one transaction to the next unless an idle cycle is drawn.
	task automatic send(logic cmd, logic [7:0] seg, logic [2:0] slot, logic [31:0] coef,
			logic [31:0] t);
		while (!steady && $urandom_range(99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= {5'd0, t, coef, slot, seg};
		s_axis_tuser  <= cmd;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// Fill a segment's six coefficients, small or full range.
	task automatic load_segment(int seg, bit wide);
		for (int p = 0; p < COEF_PER_SEGMENT; p++)
			send(CMD_LOAD, seg[7:0], p[2:0], wide ? $urandom : 32'($signed($urandom_range(
				262143)) - 131072), $urandom);
	endtask

	initial begin
		logic [31:0] t;
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_LOAD;
		s_axis_tvalid = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START_TIME;
		cfg_data = '0;
		steady = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: load the segments in use so no read hits an unwritten entry.
		for (int s = 0; s < LOADED_SEGS; s++) load_segment(s, s % 2);
		// Ignored loads: bad slots.
		send(CMD_LOAD, 8'd3, 3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send(CMD_LOAD, 8'd255, 3'd7, 32'h80000000, 32'h0);
		// Reset settings: extremes of time.
		send(CMD_EVAL, 8'hFF, 3'd7, 32'hFFFFFFFF, 32'h00000000);
		send(CMD_EVAL, 8'h00, 3'd0, 32'h0, 32'h7FFFFFFF);
		send(CMD_EVAL, 8'h00, 3'd0, 32'h0, 32'h80000000);
		send(CMD_EVAL, 8'h00, 3'd0, 32'h0, 32'h00008000);
		send(CMD_EVAL, 8'h00, 3'd0, 32'h0, 32'hFFFF8000);
		drain();

		// Phases of settings, extremes among them.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_START_TIME, 32'h80000000);
					write_reg(REG_INV_STEP, 32'hFFFFFFFF);
					write_reg(REG_SEGMENT_COUNT, 32'(LOADED_SEGS));
				end
				1: begin
					write_reg(REG_START_TIME, 32'h7FFFFFFF);
					write_reg(REG_INV_STEP, 32'd0);
					write_reg(REG_SEGMENT_COUNT, 32'd0);
				end
				2: begin
					// A unit inverse step keeps every evaluation in segment zero.
					write_reg(REG_START_TIME, 32'd0);
					write_reg(REG_INV_STEP, 32'd1);
					write_reg(REG_SEGMENT_COUNT, 32'h1FF);
				end
				default: begin
					write_reg(REG_START_TIME, $urandom_range(32'h3FFFF) - 32'h20000);
					write_reg(REG_INV_STEP, ($urandom_range(3) == 0) ? $urandom :
						$urandom_range(32'h80000, 32'h1000));
					write_reg(REG_SEGMENT_COUNT, $urandom_range(LOADED_SEGS, 1));
				end
			endcase
			steady = (ph == 4);
			for (int i = 0; i < 85; i++) begin
				if ($urandom_range(9) < 2) begin
					send(CMD_LOAD, 8'($urandom), 3'($urandom_range(7)), $urandom, $urandom);
				end else begin
					t = ($urandom_range(2) == 0) ? $urandom :
						32'($urandom_range(32'hFFFFF)) - 32'h40000;
					send(CMD_EVAL, 8'($urandom), 3'($urandom), $urandom, t);
				end
			end
			steady = 1'b0;
			drain();
		end

		if (fail_count == 0) begin
			$display("tb_quintic_spline_evaluator_unit OK");
		end else begin
			$display("tb_quintic_spline_evaluator_unit NOT OK");
		end
		$finish;
	end

endmodule
